// ===== rtl/bda_pkg.sv =====
package bda_pkg;

  // bcd digit width and ascii offset of '0'
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned CHAR_W     = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
  // double dabble correction threshold and offset
  localparam logic [DIGIT_W-1:0] DD_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DD_ADD   = 4'd3;

  // queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } bda_q_status_t;

endpackage

// ===== rtl/bda_front.sv =====
module bda_front import bda_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned NDIG       = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [VALUE_BITS-1:0]   in_value,
  input  bda_q_status_t           q_status,
  output logic                    q_push,
  output logic [NDIG*DIGIT_W-1:0] q_wdata
);

  localparam int unsigned CNT_W  = $clog2(VALUE_BITS);
  localparam int unsigned BCD_W  = NDIG * DIGIT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PUSH
  } state_t;

  state_t                  state_r, state_nxt;
  logic [VALUE_BITS-1:0]   value_r, value_nxt;
  logic [BCD_W-1:0]        bcd_r, bcd_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [BCD_W-1:0]        adj;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i*DIGIT_W +: DIGIT_W] = (bcd_r[i*DIGIT_W +: DIGIT_W] >= DD_LIMIT) ?
        bcd_r[i*DIGIT_W +: DIGIT_W] + DD_ADD : bcd_r[i*DIGIT_W +: DIGIT_W];
    end
  end

  always_comb begin
    state_nxt = state_r;
    value_nxt = value_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    q_push    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          value_nxt = in_value;
          bcd_nxt   = '0;
          cnt_nxt   = CNT_W'(VALUE_BITS - 1);
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt   = {adj[BCD_W-2:0], value_r[VALUE_BITS-1]};
        value_nxt = {value_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!q_status.full) begin
          q_push    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    bcd_r   <= bcd_nxt;
    cnt_r   <= cnt_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy    = (state_r != ST_IDLE);
  assign q_wdata = bcd_r;

endmodule

// ===== rtl/bda_fifo.sv =====
module bda_fifo import bda_pkg::*; #(
  parameter int unsigned WIDTH = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output bda_q_status_t    status
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign rdata        = mem_r[rd_ptr_r];
  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);

endmodule

// ===== rtl/bda_back.sv =====
module bda_back import bda_pkg::*; #(
  parameter int unsigned NDIG = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bda_q_status_t           q_status,
  input  logic [NDIG*DIGIT_W-1:0] q_rdata,
  output logic                    q_pop,
  output logic                    out_strobe,
  output logic [CHAR_W-1:0]       out_digit_char,
  output logic                    out_last_digit
);

  localparam int unsigned BCD_W = NDIG * DIGIT_W;
  localparam int unsigned REM_W = $clog2(NDIG + 1);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t              state_r, state_nxt;
  logic [BCD_W-1:0]    bcd_r, bcd_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic                seen_r, seen_nxt;
  logic                strobe_r, strobe_nxt;
  logic [CHAR_W-1:0]   char_r, char_nxt;
  logic                last_r, last_nxt;
  logic [DIGIT_W-1:0]  top;
  logic                emit;

  assign top  = bcd_r[BCD_W-1 -: DIGIT_W];
  // leading zeros are dropped, the final digit always goes out
  assign emit = seen_r || (top != '0) || (rem_r == REM_W'(1));

  always_comb begin
    state_nxt  = state_r;
    bcd_nxt    = bcd_r;
    rem_nxt    = rem_r;
    seen_nxt   = seen_r;
    strobe_nxt = 1'b0;
    char_nxt   = char_r;
    last_nxt   = last_r;
    q_pop      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_status.empty) begin
          q_pop     = 1'b1;
          bcd_nxt   = q_rdata;
          rem_nxt   = REM_W'(NDIG);
          seen_nxt  = 1'b0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        strobe_nxt = emit;
        char_nxt   = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top};
        last_nxt   = (rem_r == REM_W'(1));
        seen_nxt   = seen_r | emit;
        bcd_nxt    = {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        rem_nxt    = rem_r - 1'b1;
        if (rem_r == REM_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    bcd_r  <= bcd_nxt;
    rem_r  <= rem_nxt;
    seen_r <= seen_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_digit_char = char_r;
  assign out_last_digit = last_r;

endmodule

// ===== rtl/binary_to_decimal_ascii_unit.sv =====
// from start the front part converts the value and queues its digits; the back part
// then walks the digit slots, leading-zero slots skipped without a strobe
// the front part takes a new item only once the last one is in the queue; its
// bit-serial double dabble loop sets the pace, and digits stream out meanwhile
// reset: synchronous active-low rst_n clears both state machines and the queue
// results cannot be stalled: each digit shows for exactly one cycle on out_strobe
module binary_to_decimal_ascii_unit import bda_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_strobe,
  output logic [CHAR_W-1:0]     out_digit_char,
  output logic                  out_last_digit
);

  // decimal digits needed for the largest value: floor(bits * log10(2)) + 1
  localparam int unsigned NDIG  = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int unsigned BCD_W = NDIG * DIGIT_W;

  // queue between the converter and the digit sequencer
  bda_q_status_t    q_status;
  logic             q_push;
  logic             q_pop;
  logic [BCD_W-1:0] q_wdata;
  logic [BCD_W-1:0] q_rdata;

  // front: takes an item while idle, shifts it into packed bcd one bit a cycle,
  // then parks the digits in the queue (waits there if the queue is full)
  bda_front #(
    .VALUE_BITS (VALUE_BITS),
    .NDIG       (NDIG)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_value (in_value),
    .q_status (q_status),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // two-entry queue so the next conversion overlaps the digit output
  bda_fifo #(
    .WIDTH (BCD_W)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  // back: walks the digits most significant first, drops leading zeros,
  // flags the least significant digit as last
  bda_back #(
    .NDIG (NDIG)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_status       (q_status),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_strobe     (out_strobe),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

endmodule

// ===== rtl/bda_checker.sv =====
module bda_checker import bda_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input logic [CHAR_W-1:0] out_digit_char,
  input logic              out_last_digit
);

  // every strobed character is a decimal digit
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_digit_char >= 6'd48) && (out_digit_char <= 6'd57))
    else $error("digit character out of range");

  // an accepted item keeps the converter busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepting an item");

  // reset leaves the unit idle with no strobe
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_strobe))
    else $error("unit not quiet after reset");

  // digits of one number come in consecutive cycles, a gap follows the last one
  a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> (out_strobe != $past(out_last_digit)))
    else $error("last digit flag inconsistent");

endmodule

bind binary_to_decimal_ascii_unit bda_checker u_bda_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_digit_char (out_digit_char),
  .out_last_digit (out_last_digit)
);

// ===== test/tb_binary_to_decimal_ascii_unit.sv =====
module tb_binary_to_decimal_ascii_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bda_pkg::*;

  localparam int unsigned VALUE_BITS = 32;
  // extra wait after the owed digits are out, so this covers the tail
  localparam int unsigned DRAIN_CYCLES = VALUE_BITS + 24;
  // slowest run: ~400 items, each with busy time, sender gap and digits, taken many times over
  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned REPORT_MAX = 10;

  // one expected digit of the decimal text
  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } digit_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [VALUE_BITS-1:0] in_value;
  logic                  out_strobe;
  logic [CHAR_W-1:0]     out_digit_char;
  logic                  out_last_digit;

  // digits still owed by the block, oldest first
  digit_t pending_digits[$];

  int unsigned mismatch_count;
  int unsigned numbers_sent;
  int unsigned digits_checked;
  int unsigned numbers_done;
  int unsigned cycle_count;
  int unsigned max_gap;
  bit          length_seen[1:MAX_DIGITS];

  binary_to_decimal_ascii_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_strobe    (out_strobe),
    .out_digit_char(out_digit_char),
    .out_last_digit(out_last_digit)
  );

  // 20 ns clock
  always #10 clk = ~clk;

  // watchdog: a hung block ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digits still owed",
               cycle_count, pending_digits.size());
      $display("binary_to_decimal_ascii_unit verification failed");
      $finish;
    end
  end

  // split a number into decimal ascii digits, most significant first,
  // and queue them as the text the block has to produce
  function automatic void queue_decimal_digits(input logic [VALUE_BITS-1:0] number);
    logic [63:0]       rest;
    logic [3:0]        digit_val[MAX_DIGITS];
    int unsigned       count;
    digit_t            item;
    rest  = 64'(number);
    count = 0;
    // zero still gives one digit
    do begin
      digit_val[count] = 4'(rest % 10);
      rest             = rest / 10;
      count++;
    end while (rest != 0 && count < MAX_DIGITS);
    length_seen[count] = 1'b1;
    for (int k = int'(count) - 1; k >= 0; k--) begin
      item.digit_char = ASCII_ZERO + CHAR_W'(digit_val[k]);
      item.last_digit = (k == 0);
      pending_digits.push_back(item);
    end
  endfunction

  // compare every strobed digit with the oldest one owed
  always @(posedge clk) begin
    digit_t want;
    if (rst_n && out_strobe) begin
      if (pending_digits.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected digit: char %0d last %0b", out_digit_char, out_last_digit);
      end else begin
        want = pending_digits.pop_front();
        digits_checked++;
        if (out_last_digit === 1'b1)
          numbers_done++;
        if (out_digit_char !== want.digit_char || out_last_digit !== want.last_digit) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("digit mismatch: expected char %0d last %0b, got char %0d last %0b",
                     want.digit_char, want.last_digit, out_digit_char, out_last_digit);
        end
      end
    end
  end

  // hand one number to the block; start stays high after acceptance so that
  // a zero gap gives back-to-back items
  task automatic send_number(input logic [VALUE_BITS-1:0] number);
    int unsigned gap;
    gap = $urandom_range(max_gap, 0);
    if (gap != 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start    <= 1'b1;
    in_value <= number;
    // busy and start as seen just before the edge decide acceptance
    do @(posedge clk); while (busy !== 1'b0);
    queue_decimal_digits(number);
    numbers_sent++;
  endtask

  // drop start and wait until every owed digit has come out
  task automatic wait_for_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random number with exactly the given count of decimal digits
  function automatic logic [VALUE_BITS-1:0] number_of_length(input int unsigned len);
    logic [63:0] lo;
    logic [63:0] hi;
    lo = 1;
    for (int i = 1; i < len; i++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (len == 1) lo = 0;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    return VALUE_BITS'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
  endfunction

  // zero, values below ten, values around powers of ten, the top of the range, bit patterns
  task automatic test_directed();
    logic [VALUE_BITS-1:0] edge_values[$];
    edge_values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101,
                    32'd999_999_999, 32'd1_000_000_000, 32'd1_000_000_001,
                    32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'hAAAA_AAAA, 32'h5555_5555, 32'd1_234_567_890,
                    32'd4_000_000_000, 32'd90_000_000, 32'd12_345};
    max_gap = 3;
    foreach (edge_values[i]) send_number(edge_values[i]);
  endtask

  // random digit counts from one to ten, random content
  task automatic test_digit_lengths();
    max_gap = 16;
    repeat (190) send_number(number_of_length($urandom_range(MAX_DIGITS, 1)));
  endtask

  // uniform over the whole 32-bit range, mostly ten-digit numbers
  task automatic test_full_range();
    max_gap = 16;
    repeat (80) send_number($urandom);
  endtask

  // numbers with runs of trailing zeros
  task automatic test_round_numbers();
    logic [63:0] scaled;
    max_gap = 8;
    repeat (40) begin
      scaled = 64'($urandom_range(99, 1));
      repeat ($urandom_range(8, 0)) scaled = scaled * 10;
      if (scaled > 64'hFFFF_FFFF) scaled = 64'hFFFF_FFFF - 64'($urandom_range(9, 0));
      send_number(VALUE_BITS'(scaled));
    end
  endtask

  // no sender gaps: start held high across items
  task automatic test_back_to_back();
    max_gap = 0;
    repeat (40) send_number(number_of_length($urandom_range(MAX_DIGITS, 1)));
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_value       = '0;
    mismatch_count = 0;
    numbers_sent   = 0;
    digits_checked = 0;
    numbers_done   = 0;
    cycle_count    = 0;
    max_gap        = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    wait_for_idle();
    test_digit_lengths();
    // sender holds off until the block has gone quiet
    wait_for_idle();
    test_full_range();
    test_round_numbers();
    wait_for_idle();
    test_back_to_back();
    wait_for_idle();

    $display("%0d numbers converted, %0d digits checked, %0d completed texts",
             numbers_sent, digits_checked, numbers_done);
    $display("digit counts 1..10 reached: %0b%0b%0b%0b%0b%0b%0b%0b%0b%0b",
             length_seen[1], length_seen[2], length_seen[3], length_seen[4],
             length_seen[5], length_seen[6], length_seen[7], length_seen[8],
             length_seen[9], length_seen[10]);
    if (mismatch_count == 0 && pending_digits.size() == 0) begin
      $display("binary_to_decimal_ascii_unit verification clean");
    end else begin
      $display("%0d mismatches, %0d digits never came", mismatch_count,
               pending_digits.size());
      $display("binary_to_decimal_ascii_unit verification failed");
    end
    $finish;
  end

endmodule
